>>> design/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants of the least-squares slope block: payload
// structs, status codes, sequencer states and datapath widths.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int LSS_MAX_POINTS = 256;
    localparam int LSS_COUNT_W    = 9;

    // Shared multiplier operand widths (signed)
    localparam int LSS_MUL_A_W = 37;
    localparam int LSS_MUL_B_W = 25;
    localparam int LSS_PROD_W  = LSS_MUL_A_W + LSS_MUL_B_W;

    // Divider: |num| < 2^44, scaled by 2^16; denominator below 2^41
    localparam int LSS_NUM_W  = 46;
    localparam int LSS_DEN_W  = 42;
    localparam int LSS_QUO_W  = 60;
    localparam int LSS_DVS_W  = 41;
    localparam int LSS_STEP_W = 6;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [11:0]        x_value;
        logic signed [15:0] y_value;
        logic               last_point;
    } lss_in_t;

    typedef struct packed {
        logic signed [61:0] slope;
        logic [8:0]         points_used;
        logic [1:0]         fit_status;
    } lss_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_XX,
        ST_MUL_XY,
        ST_ACCUM,
        ST_PROD_A,
        ST_PROD_B,
        ST_PROD_C,
        ST_PROD_D,
        ST_DEN_SUB,
        ST_CHECK,
        ST_DIVIDE,
        ST_DELIVER
    } lss_state_t;

endpackage

>>> design/lss_mul.sv
// ----------------------------------------------------------------------------
// lss_mul
// Shared signed multiplier with a registered product; result is available
// in the cycle after the operands are presented.
// ----------------------------------------------------------------------------
module lss_mul
    import lss_pkg::*;
(
    input  logic                          clk,
    input  logic signed [LSS_MUL_A_W-1:0] a,
    input  logic signed [LSS_MUL_B_W-1:0] b,
    output logic signed [LSS_PROD_W-1:0]  product
);

    logic signed [LSS_PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= LSS_PROD_W'(a) * LSS_PROD_W'(b);
    end

    assign product = product_reg;

endmodule

>>> design/lss_div.sv
// ----------------------------------------------------------------------------
// lss_div
// Restoring unsigned divider, one quotient bit per cycle. Pulses done for
// one cycle when the quotient is ready; quotient holds until the next start.
// ----------------------------------------------------------------------------
module lss_div
    import lss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [LSS_QUO_W-1:0] dividend,
    input  logic [LSS_DVS_W-1:0] divisor,
    output logic                 busy,
    output logic                 done,
    output logic [LSS_QUO_W-1:0] quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [LSS_STEP_W-1:0] step_reg, step_next;
    logic [LSS_DVS_W-1:0]  rem_reg, rem_next;
    logic [LSS_DVS_W-1:0]  dvs_reg, dvs_next;
    logic [LSS_QUO_W-1:0]  dq_reg, dq_next;
    logic [LSS_DVS_W:0]    shifted;
    logic [LSS_DVS_W+1:0]  diff;

    assign shifted = {rem_reg, dq_reg[LSS_QUO_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dq_next   = dq_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = LSS_STEP_W'(LSS_QUO_W - 1);
            rem_next  = '0;
            dvs_next  = divisor;
            dq_next   = dividend;
        end
        else if (busy_reg)
        begin
            // keep the trial difference when it did not go negative
            if (!diff[LSS_DVS_W+1])
                rem_next = diff[LSS_DVS_W-1:0];
            else
                rem_next = shifted[LSS_DVS_W-1:0];
            dq_next = {dq_reg[LSS_QUO_W-2:0], ~diff[LSS_DVS_W+1]};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                step_next = step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dq_reg  <= dq_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dq_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(start))
        else $error("divider went busy without start");
`endif

endmodule

>>> design/least_squares_slope_top.sv
// ----------------------------------------------------------------------------
// least_squares_slope_top
// Least-squares slope of a set of points, one shared multiplier and an
// iterative divider under a small sequencer.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) carries one point per transfer;
// last_point closes the set. Output channel (out_valid/out_ready/out_data)
// carries one result per set: slope (16 fraction bits, truncated toward
// zero), points_used and fit_status.
// A point that fits passes ST_MUL_XX, ST_MUL_XY and ST_ACCUM: the shared
// multiplier forms x*x and x*y in turn before the sums update. A point
// arriving with the set full is not summed and only marks overflow. After
// the last point the sequencer forms numerator and denominator on the same
// multiplier, checks the denominator, then runs the bit-serial divider (one
// quotient bit per cycle, 60 bits) and loads the output register. With a
// zero denominator the divider is skipped.
// in_ready is low while a point or a fit is in progress. The output register
// holds a result until taken; a stalled receiver only blocks the next fit
// at its final step, points of the next set keep accumulating meanwhile.
// Reset clears all sums, the point count and the overflow flag.
// ----------------------------------------------------------------------------
module least_squares_slope_top
    import lss_pkg::*;
#(
    parameter int MAX_POINTS = LSS_MAX_POINTS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  lss_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output lss_out_t out_data
);

    lss_state_t state_reg, state_next;

    logic [19:0]            sum_x_reg, sum_x_next;
    logic [31:0]            sum_xx_reg, sum_xx_next;
    logic signed [23:0]     sum_y_reg, sum_y_next;
    logic signed [35:0]     sum_xy_reg, sum_xy_next;
    logic [LSS_COUNT_W-1:0] count_reg, count_next;
    logic                   ovf_reg, ovf_next;

    logic [11:0]            x_reg, x_next;
    logic signed [15:0]     y_reg, y_next;
    logic                   last_reg, last_next;
    logic signed [LSS_NUM_W-1:0] num_reg, num_next;
    logic signed [LSS_DEN_W-1:0] den_reg, den_next;

    logic     out_valid_reg, out_valid_next;
    lss_out_t out_data_reg, out_data_next;

    logic signed [LSS_MUL_A_W-1:0] mul_a;
    logic signed [LSS_MUL_B_W-1:0] mul_b;
    logic signed [LSS_PROD_W-1:0]  product;

    logic                 div_start;
    logic                 div_busy;
    logic                 div_done;
    logic [LSS_QUO_W-1:0] quotient;
    logic [LSS_NUM_W-1:0] num_mag;
    logic [LSS_QUO_W-1:0] dividend;

    logic in_fire;
    logic set_full;
    logic den_pos;
    logic deliver;
    logic signed [61:0] slope_val;

    assign in_fire  = in_valid && in_ready;
    assign set_full = (count_reg == LSS_COUNT_W'(MAX_POINTS));
    assign den_pos  = !den_reg[LSS_DEN_W-1] && (den_reg != '0);
    assign num_mag  = num_reg[LSS_NUM_W-1] ? LSS_NUM_W'(-num_reg) : LSS_NUM_W'(num_reg);
    assign dividend = {num_mag[LSS_QUO_W-17:0], 16'd0};

    lss_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    lss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (den_reg[LSS_DVS_W-1:0]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!set_full)
                        state_next = ST_MUL_XX;
                    else if (in_data.last_point)
                        state_next = ST_PROD_A;
                end
            end
            ST_MUL_XX:  state_next = ST_MUL_XY;
            ST_MUL_XY:  state_next = ST_ACCUM;
            ST_ACCUM:   state_next = last_reg ? ST_PROD_A : ST_IDLE;
            ST_PROD_A:  state_next = ST_PROD_B;
            ST_PROD_B:  state_next = ST_PROD_C;
            ST_PROD_C:  state_next = ST_PROD_D;
            ST_PROD_D:  state_next = ST_DEN_SUB;
            ST_DEN_SUB: state_next = ST_CHECK;
            ST_CHECK:   state_next = den_pos ? ST_DIVIDE : ST_DELIVER;
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operands and strobes
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        deliver   = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_MUL_XX:
            begin
                mul_a = {25'd0, x_reg};
                mul_b = {13'd0, x_reg};
            end
            ST_MUL_XY:
            begin
                mul_a = {{21{y_reg[15]}}, y_reg};
                mul_b = {13'd0, x_reg};
            end
            ST_PROD_A:
            begin
                mul_a = {sum_xy_reg[35], sum_xy_reg};
                mul_b = {16'd0, count_reg};
            end
            ST_PROD_B:
            begin
                mul_a = {17'd0, sum_x_reg};
                mul_b = {sum_y_reg[23], sum_y_reg};
            end
            ST_PROD_C:
            begin
                mul_a = {5'd0, sum_xx_reg};
                mul_b = {16'd0, count_reg};
            end
            ST_PROD_D:
            begin
                mul_a = {17'd0, sum_x_reg};
                mul_b = {5'd0, sum_x_reg};
            end
            ST_CHECK:
                div_start = den_pos;
            ST_DELIVER:
                deliver = !out_valid_reg || out_ready;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign slope_val = !den_pos ? 62'sd0
                     : num_reg[LSS_NUM_W-1] ? -$signed({2'b00, quotient})
                     : $signed({2'b00, quotient});

    // datapath
    always_comb
    begin
        sum_x_next     = sum_x_reg;
        sum_xx_next    = sum_xx_reg;
        sum_y_next     = sum_y_reg;
        sum_xy_next    = sum_xy_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        last_next      = last_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (in_fire)
        begin
            x_next    = in_data.x_value;
            y_next    = in_data.y_value;
            last_next = in_data.last_point;
            if (set_full)
                ovf_next = 1'b1;
        end

        case (state_reg)
            ST_MUL_XY:
                sum_xx_next = sum_xx_reg + product[31:0];
            ST_ACCUM:
            begin
                sum_xy_next = sum_xy_reg + product[35:0];
                sum_x_next  = sum_x_reg + {8'd0, x_reg};
                sum_y_next  = sum_y_reg + {{8{y_reg[15]}}, y_reg};
                count_next  = count_reg + 1'b1;
            end
            ST_PROD_B:
                num_next = product[LSS_NUM_W-1:0];
            ST_PROD_C:
                num_next = num_reg - product[LSS_NUM_W-1:0];
            ST_PROD_D:
                den_next = product[LSS_DEN_W-1:0];
            ST_DEN_SUB:
                den_next = den_reg - product[LSS_DEN_W-1:0];
            default:
            begin
                num_next = num_reg;
            end
        endcase

        if (deliver)
        begin
            out_valid_next            = 1'b1;
            out_data_next.slope       = slope_val;
            out_data_next.points_used = count_reg;
            if (ovf_reg)
                out_data_next.fit_status = STATUS_OVERFLOW;
            else if (!den_pos)
                out_data_next.fit_status = STATUS_ZERO_DEN;
            else
                out_data_next.fit_status = STATUS_OK;
            // clear the sums for the next set
            sum_x_next  = '0;
            sum_xx_next = '0;
            sum_y_next  = '0;
            sum_xy_next = '0;
            count_next  = '0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_x_reg     <= '0;
            sum_xx_reg    <= '0;
            sum_y_reg     <= '0;
            sum_xy_reg    <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_x_reg     <= sum_x_next;
            sum_xx_reg    <= sum_xx_next;
            sum_y_reg     <= sum_y_next;
            sum_xy_reg    <= sum_xy_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        last_reg     <= last_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LSS_COUNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");
    a_div_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> den_pos)
        else $error("divider started with non-positive denominator");
    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_busy)
        else $error("input ready while divider busy");
    a_deliver_clears: assert property (@(posedge clk) disable iff (!rst_n)
        deliver |=> (count_reg == '0) && !ovf_reg && out_valid_reg)
        else $error("result loaded without clearing the sums");
`endif

endmodule

>>> verif/tb_least_squares_slope_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_least_squares_slope_top
// Self-checking bench for the least-squares slope block. Point sets go in
// over the valid/ready input channel while a behavioral fit predictor tracks
// the running sums. Each fit result on the output channel is compared field
// by field with the oldest predicted fit. Covers corner points, zero
// denominators, a full set and sets past capacity, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module tb_least_squares_slope_top;
    import lss_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 150;
    localparam int IDLE_PCT     = 9;
    localparam int MAX_REPORTS  = 10;
    localparam int ITEM_TARGET  = 1300;

    typedef enum int {
        X_FULL,
        X_CORNER,
        X_CONST,
        X_NARROW
    } x_pattern_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    lss_in_t  in_data;
    logic     out_valid;
    logic     out_ready = 1'b0;
    lss_out_t out_data;

    // Predictor state, kept at the block's widths
    logic [19:0]        fit_sum_x;
    logic [31:0]        fit_sum_xx;
    logic signed [23:0] fit_sum_y;
    logic signed [35:0] fit_sum_xy;
    logic [8:0]         fit_count;
    logic               fit_overflow;

    lss_out_t expected_fits[$];
    lss_out_t got_fit;
    lss_out_t want_fit;

    int  error_count  = 0;
    int  stall_cycles = 0;
    int  items_sent   = 0;
    bit  no_idle      = 1'b0;

    least_squares_slope_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
    endfunction

    function automatic void clear_fit_sums();
        fit_sum_x    = '0;
        fit_sum_xx   = '0;
        fit_sum_y    = '0;
        fit_sum_xy   = '0;
        fit_count    = '0;
        fit_overflow = 1'b0;
    endfunction

    // Accumulate one accepted point; on the last point queue the fitted slope
    function automatic void predict_fit(lss_in_t pt);
        longint   n;
        longint   sx;
        longint   sxx;
        longint   sy;
        longint   sxy;
        longint   num;
        longint   den;
        longint   quo;
        lss_out_t fit;
        if (fit_count < LSS_MAX_POINTS) begin
            fit_sum_x  = fit_sum_x + 20'(pt.x_value);
            fit_sum_xx = fit_sum_xx + 32'(pt.x_value) * 32'(pt.x_value);
            fit_sum_y  = fit_sum_y + 24'(pt.y_value);
            fit_sum_xy = fit_sum_xy + 36'($signed({1'b0, pt.x_value})) * 36'(pt.y_value);
            fit_count  = fit_count + 1'b1;
        end
        else
        begin
            fit_overflow = 1'b1;
        end
        if (pt.last_point) begin
            n   = longint'(fit_count);
            sx  = longint'(fit_sum_x);
            sxx = longint'(fit_sum_xx);
            sy  = longint'(fit_sum_y);
            sxy = longint'(fit_sum_xy);
            num = n * sxy - sx * sy;
            den = n * sxx - sx * sx;
            quo = 0;
            fit.fit_status = STATUS_OK;
            if (den > 0)
                quo = (num * 65536) / den;
            else
                fit.fit_status = STATUS_ZERO_DEN;
            if (fit_overflow)
                fit.fit_status = STATUS_OVERFLOW;
            fit.slope       = quo[61:0];
            fit.points_used = fit_count;
            expected_fits.push_back(fit);
            clear_fit_sums();
        end
    endfunction

    // Leaves in_valid high after the transfer; the next call or caller drops it
    task automatic send_point(input logic [11:0] x, input logic [15:0] y, input logic last);
        lss_in_t pt;
        pt.x_value    = x;
        pt.y_value    = y;
        pt.last_point = last;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= pt;
        do
            @(posedge clk);
        while (!in_ready);
        predict_fit(pt);
        items_sent++;
    endtask

    task automatic send_set(input int len, input x_pattern_t pat);
        logic [11:0] x;
        logic [15:0] y;
        logic [11:0] base_x;
        base_x = 12'($urandom_range(0, 4095));
        for (int i = 0; i < len; i++) begin
            y = 16'($urandom());
            case (pat)
                X_FULL:   x = 12'($urandom());
                X_CORNER:
                begin
                    x = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                    y = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                end
                X_CONST:  x = base_x;
                default:  x = base_x + 12'($urandom_range(0, 3));
            endcase
            send_point(x, y, i == len - 1);
        end
    endtask

    task automatic wait_fits_drained();
        while (expected_fits.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        // single point: zero denominator
        send_point(12'hFFF, 16'h8000, 1'b1);
        // equal x: zero denominator
        send_point(12'h000, 16'h7FFF, 1'b0);
        send_point(12'h000, 16'h8000, 1'b1);
        // steepest rise and fall across the full x range
        send_point(12'h000, 16'h8000, 1'b0);
        send_point(12'hFFF, 16'h7FFF, 1'b1);
        send_point(12'h000, 16'h7FFF, 1'b0);
        send_point(12'hFFF, 16'h8000, 1'b1);
        // flat line
        send_point(12'd10, 16'd5, 1'b0);
        send_point(12'd20, 16'd5, 1'b0);
        send_point(12'd30, 16'd5, 1'b1);
        // uneven spacing, fraction truncated toward zero
        send_point(12'd1, 16'd0, 1'b0);
        send_point(12'd2, 16'd1, 1'b0);
        send_point(12'd4, -16'sd3, 1'b0);
        send_point(12'hFFF, 16'd100, 1'b1);
    endtask

    task automatic test_full_set();
        // exactly at capacity, extreme values push the sums to their widest
        send_set(LSS_MAX_POINTS, X_CORNER);
    endtask

    task automatic test_past_capacity();
        // last point lands on a full set and is dropped
        send_set(LSS_MAX_POINTS + 1, X_FULL);
        send_set(LSS_MAX_POINTS + 14, X_NARROW);
    endtask

    task automatic run_small_sets(input int item_limit);
        int         roll;
        x_pattern_t pat;
        while (items_sent < item_limit) begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                pat = X_FULL;
            else if (roll < 75)
                pat = X_NARROW;
            else if (roll < 88)
                pat = X_CORNER;
            else
                pat = X_CONST;
            send_set($urandom_range(1, 12), pat);
        end
    endtask

    task automatic test_random_sets();
        run_small_sets(items_sent + (ITEM_TARGET - items_sent - 150) / 2);
        // hold the sender until every fit is out
        in_valid <= 1'b0;
        wait_fits_drained();
        run_small_sets(ITEM_TARGET - 150);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_small_sets(ITEM_TARGET);
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            got_fit = out_data;
            if (expected_fits.size() == 0) begin
                note_error($sformatf("unexpected fit: slope %0d points %0d status %0d",
                                     got_fit.slope, got_fit.points_used, got_fit.fit_status));
            end
            else
            begin
                want_fit = expected_fits.pop_front();
                if (got_fit.slope !== want_fit.slope)
                    note_error($sformatf("slope expected %0d got %0d",
                                         want_fit.slope, got_fit.slope));
                if (got_fit.points_used !== want_fit.points_used)
                    note_error($sformatf("points_used expected %0d got %0d",
                                         want_fit.points_used, got_fit.points_used));
                if (got_fit.fit_status !== want_fit.fit_status)
                    note_error($sformatf("fit_status expected %0d got %0d",
                                         want_fit.fit_status, got_fit.fit_status));
            end
        end
    end

    // Count cycles without any transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("tb_least_squares_slope_top NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        clear_fit_sums();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_set();
        test_past_capacity();
        test_random_sets();
        test_back_to_back();

        in_valid <= 1'b0;
        wait_fits_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_fits.size() != 0)
            note_error($sformatf("%0d fits never arrived", expected_fits.size()));

        if (error_count == 0)
            $display("tb_least_squares_slope_top OK");
        else
            $display("tb_least_squares_slope_top NOT OK");
        $finish;
    end

endmodule

>>> files.f
design/lss_pkg.sv
design/lss_mul.sv
design/lss_div.sv
design/least_squares_slope_top.sv
verif/tb_least_squares_slope_top.sv
